/* rtl/brs_pkg.sv */
`default_nettype none
package brs_pkg;

   localparam int WORD_BITS   = 64;
   localparam int MAX_WORDS   = 8;
   localparam int RANK_BITS   = 9;
   localparam int POS_BITS    = 10;
   localparam int WIDX_BITS   = 3;
   localparam int BRANK_BITS  = 6;
   localparam logic [POS_BITS-1:0] NOT_FOUND = 10'd512;

   typedef logic [WORD_BITS-1:0] word_type;

   // per-query state handed from cell to cell
   typedef struct packed {
      logic [RANK_BITS-1:0]  remaining;
      logic                  find_zero;
      logic                  found;
      word_type              hit_word;
      logic [BRANK_BITS-1:0] hit_rank;
      logic [WIDX_BITS-1:0]  hit_idx;
   } token_type;

   function automatic logic [3:0] popcount8(input logic [7:0] b);
      logic [3:0] c;
      c = 4'd0;
      for (int i = 0; i < 8; i++) begin
         c = c + {3'd0, b[i]};
      end
      return c;
   endfunction

   function automatic logic [6:0] popcount64(input word_type w);
      logic [6:0] c;
      c = 7'd0;
      for (int j = 0; j < 8; j++) begin
         c = c + {3'd0, popcount8(w[8*j +: 8])};
      end
      return c;
   endfunction

   // position of the k-th set bit of a byte; caller ensures k < popcount8(b)
   function automatic logic [2:0] select8(input logic [7:0] b, input logic [2:0] k);
      logic [2:0] pos;
      logic [3:0] seen;
      logic       hit;
      pos  = 3'd0;
      seen = 4'd0;
      hit  = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (b[i] && !hit) begin
            if (seen == {1'b0, k}) begin
               pos = 3'(i);
               hit = 1'b1;
            end
            seen = seen + 4'd1;
         end
      end
      return pos;
   endfunction

endpackage
`default_nettype wire

/* rtl/brs_cell.sv */
`default_nettype none
module brs_cell #(
   parameter int IDX       = 0,
   parameter int NUM_WORDS = 8
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    in_valid,
   output logic                                         in_ready,
   input  wire brs_pkg::token_type                      in_tok,
   input  wire logic [NUM_WORDS-1:0][brs_pkg::WORD_BITS-1:0] in_words,
   output logic                                         out_valid,
   input  wire logic                                    out_ready,
   output brs_pkg::token_type                           out_tok,
   output logic [NUM_WORDS-1:0][brs_pkg::WORD_BITS-1:0] out_words
);
   import brs_pkg::*;

   logic                                  valid_ff, valid_in;
   token_type                             tok_ff, tok_in;
   logic [NUM_WORDS-1:0][WORD_BITS-1:0]   words_ff;
   word_type                              w;
   logic [6:0]                            cnt;
   logic                                  take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      w        = in_tok.find_zero ? ~in_words[IDX] : in_words[IDX];
      cnt      = popcount64(w);
      tok_in   = in_tok;
      valid_in = in_ready ? in_valid : valid_ff;
      if (!in_tok.found) begin
         if (in_tok.remaining < {2'd0, cnt}) begin
            tok_in.found    = 1'b1;
            tok_in.hit_word = w;
            tok_in.hit_rank = in_tok.remaining[BRANK_BITS-1:0];
            tok_in.hit_idx  = WIDX_BITS'(IDX);
         end else begin
            tok_in.remaining = in_tok.remaining - {2'd0, cnt};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tok_ff   <= tok_in;
         words_ff <= in_words;
      end
   end

   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;
   assign out_words = words_ff;

endmodule
`default_nettype wire

/* rtl/brs_select.sv */
`default_nettype none
module brs_select (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire brs_pkg::token_type            in_tok,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [brs_pkg::POS_BITS-1:0]       out_position
);
   import brs_pkg::*;

   // byte stage
   logic                  a_valid_ff, a_valid_in;
   logic                  a_found_ff;
   logic [WIDX_BITS-1:0]  a_idx_ff;
   logic [2:0]            a_byte_ff, a_byte_in;
   logic [2:0]            a_brank_ff, a_brank_in;
   logic [7:0]            a_bits_ff, a_bits_in;
   logic                  a_ready, a_take;
   logic [6:0]            acc;
   logic [6:0]            upto;
   logic                  hit;

   // output stage
   logic                  o_valid_ff, o_valid_in;
   logic [POS_BITS-1:0]   o_pos_ff, o_pos_in;
   logic                  o_take;

   always_comb begin
      acc        = 7'd0;
      upto       = 7'd0;
      hit        = 1'b0;
      a_byte_in  = 3'd0;
      a_brank_in = 3'd0;
      // walk bytes low to high, stop at the one holding the wanted bit
      for (int j = 0; j < 8; j++) begin
         upto = acc + {3'd0, popcount8(in_tok.hit_word[8*j +: 8])};
         if (!hit && ({1'b0, in_tok.hit_rank} < upto)) begin
            hit        = 1'b1;
            a_byte_in  = 3'(j);
            a_brank_in = 3'({1'b0, in_tok.hit_rank} - acc);
         end
         acc = upto;
      end
      a_bits_in = in_tok.hit_word[8*a_byte_in +: 8];
   end

   assign in_ready   = !a_valid_ff || a_ready;
   assign a_take     = in_valid && in_ready;
   assign a_valid_in = in_ready ? in_valid : a_valid_ff;

   assign a_ready    = !o_valid_ff || out_ready;
   assign o_take     = a_valid_ff && a_ready;
   assign o_valid_in = a_ready ? a_valid_ff : o_valid_ff;

   always_comb begin
      if (a_found_ff) begin
         o_pos_in = {1'b0, a_idx_ff, a_byte_ff, select8(a_bits_ff, a_brank_ff)};
      end else begin
         o_pos_in = NOT_FOUND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_take) begin
         a_found_ff <= in_tok.found;
         a_idx_ff   <= in_tok.hit_idx;
         a_byte_ff  <= a_byte_in;
         a_brank_ff <= a_brank_in;
         a_bits_ff  <= a_bits_in;
      end
      if (o_take) begin
         o_pos_ff <= o_pos_in;
      end
   end

   assign out_valid    = o_valid_ff;
   assign out_position = o_pos_ff;

endmodule
`default_nettype wire

/* rtl/bit_rank_select_512.sv */
`default_nettype none
// Rank select over a 512-bit vector: returns the position of the rank-th
// (zero-based) set bit, or clear bit when find_zero is high, and 512 when
// there are too few. Words 0 to NUM_WORDS-1 are searched, one word per
// cell of a chain, then a two-stage byte/bit select finishes the answer.
// A new request can be taken every cycle unless rsp_stall backs up the
// chain; a result passes the cell chain, then the select stages. Each
// stage holds its word under rsp_stall and fills bubbles independently.
module bit_rank_select_512 #(
   parameter int NUM_WORDS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [63:0]                   req_word_0,
   input  wire logic [63:0]                   req_word_1,
   input  wire logic [63:0]                   req_word_2,
   input  wire logic [63:0]                   req_word_3,
   input  wire logic [63:0]                   req_word_4,
   input  wire logic [63:0]                   req_word_5,
   input  wire logic [63:0]                   req_word_6,
   input  wire logic [63:0]                   req_word_7,
   input  wire logic [brs_pkg::RANK_BITS-1:0] req_rank,
   input  wire logic                          req_find_zero,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [brs_pkg::POS_BITS-1:0]       rsp_position
);
   import brs_pkg::*;

   logic [MAX_WORDS-1:0][WORD_BITS-1:0]  all_words;
   logic [NUM_WORDS-1:0][WORD_BITS-1:0]  chain_words [NUM_WORDS+1];
   token_type                            chain_tok   [NUM_WORDS+1];
   logic [NUM_WORDS:0]                   chain_valid;
   logic [NUM_WORDS:0]                   chain_ready;

   assign all_words = {req_word_7, req_word_6, req_word_5, req_word_4,
                       req_word_3, req_word_2, req_word_1, req_word_0};

   always_comb begin
      chain_tok[0]           = '0;
      chain_tok[0].remaining = req_rank;
      chain_tok[0].find_zero = req_find_zero;
   end

   assign chain_words[0] = all_words[NUM_WORDS-1:0];
   assign chain_valid[0] = req_valid;
   assign req_stall      = !chain_ready[0];

   for (genvar k = 0; k < NUM_WORDS; k++) begin : g_cell
      brs_cell #(
         .IDX       (k),
         .NUM_WORDS (NUM_WORDS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_tok    (chain_tok[k]),
         .in_words  (chain_words[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_tok   (chain_tok[k+1]),
         .out_words (chain_words[k+1])
      );
   end

   brs_select u_select (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (chain_valid[NUM_WORDS]),
      .in_ready     (chain_ready[NUM_WORDS]),
      .in_tok       (chain_tok[NUM_WORDS]),
      .out_valid    (rsp_valid),
      .out_ready    (!rsp_stall),
      .out_position (rsp_position)
   );

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_position <= NOT_FOUND)
      else $error("position out of range");

   a_hit_idx: assert property (@(posedge clock) disable iff (reset)
      chain_valid[NUM_WORDS] && chain_tok[NUM_WORDS].found
         |-> 32'(chain_tok[NUM_WORDS].hit_idx) < NUM_WORDS)
      else $error("hit word index beyond searched words");

   a_hit_rank: assert property (@(posedge clock) disable iff (reset)
      chain_valid[NUM_WORDS] && chain_tok[NUM_WORDS].found
         |-> {1'b0, chain_tok[NUM_WORDS].hit_rank}
             < popcount64(chain_tok[NUM_WORDS].hit_word))
      else $error("residual rank not inside hit word");

endmodule
`default_nettype wire
